// File: rtl/core/vfcm_pkg.sv
// Shared types, constants and lookup functions of the voxel face culling mesher.
package vfcm_pkg;

  // Chunk geometry
  localparam int unsigned CHUNK_EDGE = 16;
  localparam int unsigned CW         = (CHUNK_EDGE > 2) ? $clog2(CHUNK_EDGE) : 1;
  localparam int unsigned AW         = 2 * CW;
  localparam int unsigned ROWS       = 1 << AW;
  localparam int unsigned COORD_W    = 4;
  // Wide enough for any coordinate plus one and for the edge length itself
  localparam int unsigned NW         = 7;
  localparam logic [NW-1:0] EDGE_N   = NW'(CHUNK_EDGE);

  // Arithmetic widths
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned PW     = COORD_W + 1 + SIZE_W;
  localparam int unsigned SW     = 34;

  // Command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_MESH    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z   = 2'd2;
  localparam logic [1:0] REG_VOXEL_SIZE = 2'd3;

  // Face codes
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] voxel_x;
    logic [COORD_W-1:0] voxel_y;
    logic [COORD_W-1:0] voxel_z;
    logic [15:0]        voxel_id;
  } in_item_t;

  typedef struct packed {
    logic               has_vertex;
    logic [2:0]         face;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic               tex_u;
    logic               tex_v;
    logic [15:0]        vertex_index;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [SIZE_W-1:0]  voxel_size;
  } cfg_t;

  // Captured voxel coordinates of the command at work
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } coord_t;

  // World values for corner offsets 0 and 1 along each axis
  typedef struct packed {
    logic signed [31:0] wx0;
    logic signed [31:0] wx1;
    logic signed [31:0] wy0;
    logic signed [31:0] wy1;
    logic signed [31:0] wz0;
    logic signed [31:0] wz1;
  } world_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR,
    ST_FETCH,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  // Row of the occupancy memory: one row per (y, z), one bit per x
  function automatic logic [AW-1:0] row_addr(logic [NW-1:0] y, logic [NW-1:0] z);
    return {z[CW-1:0], y[CW-1:0]};
  endfunction

  // Corner offset {x, y, z} of a face corner, map space
  function automatic logic [2:0] face_corner(logic [2:0] face, logic [1:0] corner);
    logic [11:0] corners;
    case (face)
      FACE_PX: corners = 12'b110_111_101_100;
      FACE_NX: corners = 12'b001_011_010_000;
      FACE_PY: corners = 12'b011_111_110_010;
      FACE_NY: corners = 12'b100_101_001_000;
      FACE_PZ: corners = 12'b101_111_011_001;
      FACE_NZ: corners = 12'b010_110_100_000;
      default: corners = '0;
    endcase
    return corners[3*corner +: 3];
  endfunction

  // Lowest face whose bit is set
  function automatic logic [2:0] first_face(logic [5:0] mask);
    logic [2:0] f;
    f = '0;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) f = 3'(i);
    end
    return f;
  endfunction

endpackage

// File: rtl/core/vfcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vfcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/vfcm_world_calc.sv
// Two-stage world coordinate unit: corner products, then origin add with saturation.
module vfcm_world_calc (
  input  logic            clk_i,
  input  vfcm_pkg::coord_t coord_i,
  input  vfcm_pkg::cfg_t   cfg_i,
  output vfcm_pkg::world_t world_o
);
  import vfcm_pkg::*;

  logic [PW-1:0] px0_q, px1_q, py0_q, py1_q, pz0_q, pz1_q;
  world_t        world_q;

  function automatic logic [PW-1:0] scale(logic [COORD_W:0] c, logic [SIZE_W-1:0] s);
    return PW'(c) * PW'(s);
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] org, logic [PW-1:0] p);
    logic signed [SW-1:0] sum;
    sum = SW'(org) + $signed({{(SW-PW){1'b0}}, p});
    if (sum[SW-1:31] == '0 || sum[SW-1:31] == '1) return sum[31:0];
    else if (sum[SW-1]) return 32'sh8000_0000;
    else return 32'sh7FFF_FFFF;
  endfunction

  // Stage 1: coordinate times voxel size, for corner offsets 0 and 1
  always_ff @(posedge clk_i) begin
    px0_q <= scale({1'b0, coord_i.x}, cfg_i.voxel_size);
    px1_q <= scale({1'b0, coord_i.x} + 1'b1, cfg_i.voxel_size);
    py0_q <= scale({1'b0, coord_i.z}, cfg_i.voxel_size);
    py1_q <= scale({1'b0, coord_i.z} + 1'b1, cfg_i.voxel_size);
    pz0_q <= scale({1'b0, coord_i.y}, cfg_i.voxel_size);
    pz1_q <= scale({1'b0, coord_i.y} + 1'b1, cfg_i.voxel_size);
  end

  // Stage 2: add origin, clamp to Q16.16 range; world Y follows map z, world Z map y
  always_ff @(posedge clk_i) begin
    world_q.wx0 <= sat_add(cfg_i.origin_x, px0_q);
    world_q.wx1 <= sat_add(cfg_i.origin_x, px1_q);
    world_q.wy0 <= sat_add(cfg_i.origin_y, py0_q);
    world_q.wy1 <= sat_add(cfg_i.origin_y, py1_q);
    world_q.wz0 <= sat_add(cfg_i.origin_z, pz0_q);
    world_q.wz1 <= sat_add(cfg_i.origin_z, pz1_q);
  end

  assign world_o = world_q;

endmodule

// File: rtl/core/vfcm_ctrl.sv
// Command sequencer: occupancy memory, neighbor fetch, face walk and output register.
module vfcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vfcm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vfcm_pkg::out_item_t out_data_o,
  output vfcm_pkg::coord_t    coord_o,
  input  vfcm_pkg::world_t    world_i
);
  import vfcm_pkg::*;

  state_e             state_q, state_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic [2:0]         step_q, step_d;
  coord_t             coord_q, coord_d;
  logic               idnz_q, idnz_d;
  logic               solid_q, solid_d;
  logic [5:0]         mask_q, mask_d;
  logic [2:0]         face_q, face_d;
  logic [1:0]         corner_q, corner_d;
  logic [15:0]        vcnt_q, vcnt_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               accept, out_free;
  logic [NW-1:0]      xe, ye, ze, xp, xm, yp, ym, zp, zm;
  logic               cin, xp_in, xm_in, yp_in, ym_in, zp_in, zm_in;
  logic [CW-1:0]      xi, xpi, xmi;
  logic [5:0]         mask_rem;
  logic [2:0]         ofs;
  logic               last_vertex;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [CHUNK_EDGE-1:0] ram_wdata, ram_rdata;

  // Handshake
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Coordinate bounds of the command at work
  assign xe    = NW'(coord_q.x);
  assign ye    = NW'(coord_q.y);
  assign ze    = NW'(coord_q.z);
  assign xp    = xe + 1'b1;
  assign xm    = xe - 1'b1;
  assign yp    = ye + 1'b1;
  assign ym    = ye - 1'b1;
  assign zp    = ze + 1'b1;
  assign zm    = ze - 1'b1;
  assign cin   = (xe < EDGE_N) && (ye < EDGE_N) && (ze < EDGE_N);
  assign xp_in = xp < EDGE_N;
  assign xm_in = coord_q.x != '0;
  assign yp_in = yp < EDGE_N;
  assign ym_in = coord_q.y != '0;
  assign zp_in = zp < EDGE_N;
  assign zm_in = coord_q.z != '0;
  assign xi    = xe[CW-1:0];
  assign xpi   = xp[CW-1:0];
  assign xmi   = xm[CW-1:0];

  // Face walk helpers
  assign mask_rem    = mask_q & ~(6'b1 << face_q);
  assign ofs         = face_corner(face_q, corner_q);
  assign last_vertex = (corner_q == 2'd3) && (mask_rem == '0);

  // Occupancy rows: bit x of row (y, z) is the solid flag
  vfcm_ram #(
    .WIDTH(CHUNK_EDGE),
    .DEPTH(ROWS)
  ) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Memory access: clearing sweep, write-back of a voxel, neighbor row reads
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_addr(ye, ze);
    ram_wdata = ram_rdata;
    ram_raddr = row_addr(ye, ze);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = row_addr(NW'(in_data_i.voxel_y), NW'(in_data_i.voxel_z));
      end
      ST_WR: begin
        ram_we        = cin;
        ram_wdata[xi] = idnz_q;
      end
      ST_FETCH: begin
        case (step_q)
          3'd0:    ram_raddr = row_addr(ye, ze);
          3'd1:    ram_raddr = row_addr(yp, ze);
          3'd2:    ram_raddr = row_addr(ym, ze);
          3'd3:    ram_raddr = row_addr(ye, zp);
          3'd4:    ram_raddr = row_addr(ye, zm);
          default: ram_raddr = row_addr(ye, ze);
        endcase
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.cmd)
            CMD_WRITE: state_d = ST_WR;
            CMD_MESH:  state_d = ST_FETCH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_WR: state_d = ST_IDLE;
      ST_FETCH: begin
        if (step_q == 3'd5) state_d = (solid_q && (mask_d != '0)) ? ST_EMIT : ST_EMPTY;
      end
      ST_EMIT:  if (out_free && last_vertex) state_d = ST_IDLE;
      ST_EMPTY: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_comb begin
    clr_addr_d  = clr_addr_q;
    step_d      = step_q;
    coord_d     = coord_q;
    idnz_d      = idnz_q;
    solid_d     = solid_q;
    mask_d      = mask_q;
    face_d      = face_q;
    corner_d    = corner_q;
    vcnt_d      = vcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: clr_addr_d = clr_addr_q + 1'b1;
      ST_IDLE: begin
        if (accept) begin
          coord_d.x = in_data_i.voxel_x;
          coord_d.y = in_data_i.voxel_y;
          coord_d.z = in_data_i.voxel_z;
          idnz_d    = in_data_i.voxel_id != '0;
          step_d    = '0;
          if (in_data_i.cmd == CMD_RESTART) vcnt_d = '0;
        end
      end
      ST_FETCH: begin
        step_d = step_q + 1'b1;
        // read data of the previous step arrives now; a set bit means emit
        case (step_q)
          3'd1: begin
            solid_d   = cin && ram_rdata[xi];
            mask_d[0] = !(xp_in && ram_rdata[xpi]);
            mask_d[1] = !(xm_in && ram_rdata[xmi]);
          end
          3'd2:    mask_d[2] = !(yp_in && ram_rdata[xi]);
          3'd3:    mask_d[3] = !(ym_in && ram_rdata[xi]);
          3'd4:    mask_d[4] = !(zp_in && ram_rdata[xi]);
          3'd5:    mask_d[5] = !(zm_in && ram_rdata[xi]);
          default: ;
        endcase
        if (step_q == 3'd5) begin
          face_d   = first_face(mask_d);
          corner_d = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.has_vertex   = 1'b1;
          out_d.face         = face_q;
          out_d.world_x      = ofs[2] ? world_i.wx1 : world_i.wx0;
          out_d.world_y      = ofs[0] ? world_i.wy1 : world_i.wy0;
          out_d.world_z      = ofs[1] ? world_i.wz1 : world_i.wz0;
          out_d.tex_u        = corner_q[0] ^ corner_q[1];
          out_d.tex_v        = corner_q[1];
          out_d.vertex_index = vcnt_q;
          out_d.last         = last_vertex;
          vcnt_d             = vcnt_q + 1'b1;
          corner_d           = corner_q + 1'b1;
          if (corner_q == 2'd3) begin
            mask_d = mask_rem;
            face_d = first_face(mask_rem);
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      step_q      <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      step_q      <= step_d;
      vcnt_q      <= vcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    coord_q  <= coord_d;
    idnz_q   <= idnz_d;
    solid_q  <= solid_d;
    mask_q   <= mask_d;
    face_q   <= face_d;
    corner_q <= corner_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign coord_o     = coord_q;

endmodule

// File: rtl/core/voxel_face_culling_mesher_core.sv
// Top level of the voxel face culling mesher: configuration registers and core wiring.
//
// One cubic chunk of CHUNK_EDGE voxels per edge, one solid bit per voxel held
// in a row memory (one row per y,z pair, one bit per x). After reset the block
// sweeps that memory to air, one row a cycle, all 2^(2*clog2(CHUNK_EDGE)) rows
// (256 at an edge of 16); in_ready_o stays low meanwhile, configuration writes
// are taken at any time. Commands are worked one at a time: a restart clears
// the vertex counter as it is taken, a voxel write does a row read, then a
// write-back, a mesh command does neighbor row reads through the single memory
// read port, then gives one result per cycle while out_ready_i allows it: 4 vertices
// for each open face, or a single empty result with last set. Result delivery may
// stall on out_ready_i; the next command is taken while the final result still waits in the output register.
module voxel_face_culling_mesher_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vfcm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vfcm_pkg::out_item_t out_data_o
);
  import vfcm_pkg::*;

  cfg_t   cfg_q;
  coord_t coord;
  world_t world;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.origin_z   <= '0;
      cfg_q.voxel_size <= SIZE_W'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data_i;
        REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data_i;
        REG_ORIGIN_Z:   cfg_q.origin_z   <= cfg_data_i;
        REG_VOXEL_SIZE: cfg_q.voxel_size <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Command sequencer with the occupancy memory
  vfcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .coord_o    (coord),
    .world_i    (world)
  );

  // Corner world coordinates of the voxel at work
  vfcm_world_calc u_world_calc (
    .clk_i  (clk_i),
    .coord_i(coord),
    .cfg_i  (cfg_q),
    .world_o(world)
  );

`ifndef SYNTHESIS
  // An empty result always closes its mesh command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_vertex |-> out_data_o.last)
    else $error("empty result without last");

  // Vertex faces stay within the six face codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_vertex |-> out_data_o.face <= FACE_NZ)
    else $error("vertex face out of range");

  // Write and mesh commands keep the input closed in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_data_i.cmd == CMD_WRITE || in_data_i.cmd == CMD_MESH) |=> !in_ready_o)
    else $error("input taken while command busy");
`endif

endmodule
